FILE: design/sme_pkg.sv
`timescale 1ns / 1ps

package sme_pkg;

  // Default sizes of the stack, the local bank and the constant pool
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int LOCAL_COUNT_DEF = 256;
  localparam int POOL_DEPTH_DEF  = 256;

  // Number of top-of-stack words held in flops
  localparam int TOS_REGS = 4;

  typedef enum logic [4:0] {
    OP_BIPUSH  = 5'd0,
    OP_ADD     = 5'd1,
    OP_SUB     = 5'd2,
    OP_AND     = 5'd3,
    OP_OR      = 5'd4,
    OP_DUP     = 5'd5,
    OP_SWAP    = 5'd6,
    OP_OUT     = 5'd7,
    OP_IN      = 5'd8,
    OP_GOTO    = 5'd9,
    OP_IFEQ    = 5'd10,
    OP_IFLT    = 5'd11,
    OP_ICMPEQ  = 5'd12,
    OP_LDC     = 5'd13,
    OP_STORE   = 5'd14,
    OP_LOAD    = 5'd15,
    OP_INC     = 5'd16,
    OP_WSTORE  = 5'd17,
    OP_WLOAD   = 5'd18,
    OP_WINC    = 5'd19,
    OP_POOLWR  = 5'd20
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_INDEX = 3'd3,
    ST_BADOP = 3'd4
  } status_t;

  // Decoded instruction class
  typedef struct packed {
    logic [1:0] pops;
    logic [1:0] pushes;
    logic       bad;
    logic       loc;    // touches the local bank
    logic       pool;   // touches the constant pool
    logic       wide;   // 16-bit local index
  } dec_t;

endpackage

FILE: design/sme_in_if.sv
`timescale 1ns / 1ps

interface sme_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  opcode;
  logic [15:0] operand;
  logic signed [7:0]  increment;
  logic [7:0]  in_char;
  logic        in_end;
  logic [31:0] pc_now;
  logic signed [31:0] pool_value;

  modport source (output valid, opcode, operand, increment, in_char, in_end, pc_now,
                  pool_value, input ready);
  modport sink (input valid, opcode, operand, increment, in_char, in_end, pc_now,
                pool_value, output ready);
endinterface

FILE: design/sme_out_if.sv
`timescale 1ns / 1ps

interface sme_out_if #(parameter int DW = 11);
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        pc_written;
  logic [31:0] next_pc;
  logic signed [31:0] top_value;
  logic [DW-1:0] depth_now;

  modport source (output valid, status, out_valid, out_char, pc_written, next_pc,
                  top_value, depth_now, input ready);
  modport sink (input valid, status, out_valid, out_char, pc_written, next_pc,
                top_value, depth_now, output ready);
endinterface

FILE: design/sme_decode.sv
`timescale 1ns / 1ps

module sme_decode (
  input  logic [4:0]    opcode,
  output sme_pkg::dec_t dec
);

  // Stack effect and resource class per opcode
  always_comb begin
    dec = '0;
    case (sme_pkg::op_t'(opcode))
      sme_pkg::OP_BIPUSH, sme_pkg::OP_IN: begin
        dec.pushes = 2'd1;
      end
      sme_pkg::OP_LDC: begin
        dec.pushes = 2'd1;
        dec.pool   = 1'b1;
      end
      sme_pkg::OP_LOAD: begin
        dec.pushes = 2'd1;
        dec.loc    = 1'b1;
      end
      sme_pkg::OP_WLOAD: begin
        dec.pushes = 2'd1;
        dec.loc    = 1'b1;
        dec.wide   = 1'b1;
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_AND, sme_pkg::OP_OR: begin
        dec.pops   = 2'd2;
        dec.pushes = 2'd1;
      end
      sme_pkg::OP_DUP: begin
        dec.pops   = 2'd1;
        dec.pushes = 2'd2;
      end
      sme_pkg::OP_SWAP: begin
        dec.pops   = 2'd2;
        dec.pushes = 2'd2;
      end
      sme_pkg::OP_OUT, sme_pkg::OP_IFEQ, sme_pkg::OP_IFLT: begin
        dec.pops = 2'd1;
      end
      sme_pkg::OP_STORE: begin
        dec.pops = 2'd1;
        dec.loc  = 1'b1;
      end
      sme_pkg::OP_WSTORE: begin
        dec.pops = 2'd1;
        dec.loc  = 1'b1;
        dec.wide = 1'b1;
      end
      sme_pkg::OP_ICMPEQ: begin
        dec.pops = 2'd2;
      end
      sme_pkg::OP_GOTO: begin
        dec = '0;
      end
      sme_pkg::OP_INC: begin
        dec.loc = 1'b1;
      end
      sme_pkg::OP_WINC: begin
        dec.loc  = 1'b1;
        dec.wide = 1'b1;
      end
      sme_pkg::OP_POOLWR: begin
        dec.pool = 1'b1;
      end
      default: begin
        dec.bad = 1'b1;
      end
    endcase
  end

endmodule

FILE: design/stack_machine_execute_unit.sv
`timescale 1ns / 1ps

// Stack machine execute unit.
// in_if carries one decoded instruction per beat (valid/ready); out_if returns
// exactly one result beat per instruction, in order: status, character output,
// new pc for branches and wide forms, top of stack and stack depth.
// The accepting edge registers the instruction and the local/pool read data
// into the instruction register; execution then writes the result register,
// which drives out_if.valid. Throughput is one instruction per cycle while
// out_if.ready stays high; the top four stack words sit in flops and the two
// words below them are prefetched every cycle over the two stack memory read
// ports, so no stack effect ever stalls the unit.
// After reset the local bank is cleared one word per cycle, with in_if.ready
// low until the sweep ends; the stack is empty. The constant pool and stack
// memory are not cleared.
// When out_if.ready is low the result register holds, the instruction
// register fills and then in_if.ready drops; nothing is lost.
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int LOCAL_COUNT = sme_pkg::LOCAL_COUNT_DEF,
  parameter int POOL_DEPTH  = sme_pkg::POOL_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sme_in_if.sink    in_if,
  sme_out_if.source out_if
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(LOCAL_COUNT);
  localparam int PW  = $clog2(POOL_DEPTH);
  localparam int TR  = sme_pkg::TOS_REGS;

  // Storage
  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] loc_mem [LOCAL_COUNT];
  logic [31:0] pool_mem [POOL_DEPTH];

  // Instruction register
  logic        ir_v_r;
  logic [4:0]  ir_op_r;
  logic [15:0] ir_opnd_r;
  logic [7:0]  ir_inc_r;
  logic [7:0]  ir_ch_r;
  logic        ir_end_r;
  logic [31:0] ir_pc_r;
  logic [31:0] ir_pval_r;
  logic [31:0] loc_q_r;
  logic [31:0] pool_q_r;

  // Stack state
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [31:0]    tos_r [TR];
  logic [31:0]    tos_nxt [TR];
  logic [31:0]    pf0_r, pf1_r;

  // Local bank clearing sweep
  logic          clr_busy_r;
  logic [LW-1:0] clr_idx_r;

  // Result register
  logic        ov_r;
  logic [2:0]  o_status_r;
  logic        o_ov_r;
  logic [7:0]  o_char_r;
  logic        o_pw_r;
  logic [31:0] o_npc_r;
  logic [31:0] o_top_r;
  logic [SPW-1:0] o_depth_r;

  logic in_fire, ex_fire;
  sme_pkg::dec_t dec;

  assign ex_fire     = ir_v_r && (!ov_r || out_if.ready);
  assign in_if.ready = !clr_busy_r && (!ir_v_r || ex_fire);
  assign in_fire     = in_if.valid && in_if.ready;

  sme_decode u_dec (
    .opcode (ir_op_r),
    .dec    (dec)
  );

  // Execute
  logic [15:0] lidx;
  logic        st_under, st_over, st_index;
  logic [2:0]  status;
  logic        ok;
  logic [SPW:0] depth_after;
  logic [31:0] a, b, r0, r1, inc32, off32, npc;
  logic        taken, pw, ov;
  logic [31:0] src [TR+2];
  logic [31:0] sh  [TR];
  logic [31:0] full [TR+1];
  logic        spill;
  logic        lw_en;
  logic [LW-1:0] lw_addr;
  logic [31:0] lw_data;
  logic        pw_en;

  always_comb begin
    lidx  = dec.wide ? ir_opnd_r : {8'd0, ir_opnd_r[7:0]};
    a     = tos_r[0];
    b     = tos_r[1];
    inc32 = {{24{ir_inc_r[7]}}, ir_inc_r};
    off32 = {{16{ir_opnd_r[15]}}, ir_opnd_r};

    // fault checks, underflow before index
    st_under    = sp_r < SPW'(dec.pops);
    depth_after = {1'b0, sp_r} - (SPW+1)'(dec.pops) + (SPW+1)'(dec.pushes);
    st_over     = depth_after > (SPW+1)'(STACK_DEPTH);
    st_index    = (dec.loc && (32'(lidx) >= LOCAL_COUNT)) ||
                  (dec.pool && (32'(ir_opnd_r) >= POOL_DEPTH));
    if (dec.bad)       status = sme_pkg::ST_BADOP;
    else if (st_under) status = sme_pkg::ST_UNDER;
    else if (st_over)  status = sme_pkg::ST_OVER;
    else if (st_index) status = sme_pkg::ST_INDEX;
    else               status = sme_pkg::ST_OK;
    ok = (status == sme_pkg::ST_OK);

    // operation results
    r0 = '0;
    r1 = '0;
    taken = 1'b0;
    pw = 1'b0;
    ov = 1'b0;
    lw_en = 1'b0;
    lw_data = '0;
    case (sme_pkg::op_t'(ir_op_r))
      sme_pkg::OP_BIPUSH: r0 = {{24{ir_opnd_r[7]}}, ir_opnd_r[7:0]};
      sme_pkg::OP_ADD:    r0 = b + a;
      sme_pkg::OP_SUB:    r0 = b - a;
      sme_pkg::OP_AND:    r0 = b & a;
      sme_pkg::OP_OR:     r0 = b | a;
      sme_pkg::OP_DUP: begin
        r0 = a;
        r1 = a;
      end
      sme_pkg::OP_SWAP: begin
        r0 = a;
        r1 = b;
      end
      sme_pkg::OP_OUT:    ov = 1'b1;
      sme_pkg::OP_IN:     r0 = (ir_end_r || ir_ch_r == 8'hFF) ? 32'd0 : {24'd0, ir_ch_r};
      sme_pkg::OP_GOTO: begin
        taken = 1'b1;
        pw = 1'b1;
      end
      sme_pkg::OP_IFEQ: begin
        taken = (a == 32'd0);
        pw = 1'b1;
      end
      sme_pkg::OP_IFLT: begin
        taken = a[31];
        pw = 1'b1;
      end
      sme_pkg::OP_ICMPEQ: begin
        taken = (a == b);
        pw = 1'b1;
      end
      sme_pkg::OP_LDC:    r0 = pool_q_r;
      sme_pkg::OP_STORE, sme_pkg::OP_WSTORE: begin
        lw_en = 1'b1;
        lw_data = a;
      end
      sme_pkg::OP_LOAD, sme_pkg::OP_WLOAD: r0 = loc_q_r;
      sme_pkg::OP_INC, sme_pkg::OP_WINC: begin
        lw_en = 1'b1;
        lw_data = loc_q_r + inc32;
      end
      default: r0 = '0;
    endcase
    npc = taken ? (ir_pc_r + off32 - 32'd1) : (ir_pc_r + 32'd2);
    if (ir_op_r == sme_pkg::OP_WSTORE || ir_op_r == sme_pkg::OP_WLOAD) begin
      pw = 1'b1;
      npc = ir_pc_r + 32'd3;
    end
    if (ir_op_r == sme_pkg::OP_WINC) begin
      pw = 1'b1;
      npc = ir_pc_r + 32'd4;
    end
    lw_en   = lw_en && ok && ex_fire;
    lw_addr = lidx[LW-1:0];
    pw_en   = ok && ex_fire && ir_op_r == sme_pkg::OP_POOLWR;

    // stack effect on the top-of-stack flops: drop pops, then push
    for (int i = 0; i < TR; i++) src[i] = tos_r[i];
    src[TR]   = pf0_r;
    src[TR+1] = pf1_r;
    for (int i = 0; i < TR; i++) sh[i] = src[i + int'(dec.pops)];
    for (int i = 0; i <= TR; i++) begin
      if (dec.pushes == 2'd2)      full[i] = (i == 0) ? r1 : (i == 1) ? r0 : sh[i-2];
      else if (dec.pushes == 2'd1) full[i] = (i == 0) ? r0 : sh[i-1];
      else                         full[i] = (i < TR) ? sh[i] : '0;
    end

    sp_nxt = sp_r;
    for (int i = 0; i < TR; i++) tos_nxt[i] = tos_r[i];
    spill = 1'b0;
    if (ex_fire && ok) begin
      sp_nxt = depth_after[SPW-1:0];
      for (int i = 0; i < TR; i++) tos_nxt[i] = full[i];
      spill = (dec.pushes > dec.pops) && (sp_r >= SPW'(TR));
    end
  end

  // Stack memory: spill below the flops, prefetch the two words under them
  logic [SAW-1:0] spill_addr, pf0_addr, pf1_addr;
  assign spill_addr = SAW'(sp_r - SPW'(TR));
  assign pf0_addr   = SAW'(sp_nxt - SPW'(TR + 1));
  assign pf1_addr   = SAW'(sp_nxt - SPW'(TR + 2));

  always_ff @(posedge clk) begin
    if (spill) stk_mem[spill_addr] <= full[TR];
  end

  always_ff @(posedge clk) begin
    if (spill && spill_addr == pf0_addr) pf0_r <= full[TR];
    else                                 pf0_r <= stk_mem[pf0_addr];
    if (spill && spill_addr == pf1_addr) pf1_r <= full[TR];
    else                                 pf1_r <= stk_mem[pf1_addr];
  end

  // Local bank: clear sweep after reset, read at accept with write forwarding
  logic [15:0]   in_lidx;
  logic [LW-1:0] loc_raddr;
  assign in_lidx   = (in_if.opcode == sme_pkg::OP_WSTORE || in_if.opcode == sme_pkg::OP_WLOAD ||
                      in_if.opcode == sme_pkg::OP_WINC) ? in_if.operand
                                                        : {8'd0, in_if.operand[7:0]};
  assign loc_raddr = in_lidx[LW-1:0];

  always_ff @(posedge clk) begin
    if (clr_busy_r)  loc_mem[clr_idx_r] <= '0;
    else if (lw_en)  loc_mem[lw_addr] <= lw_data;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (lw_en && lw_addr == loc_raddr) loc_q_r <= lw_data;
      else                               loc_q_r <= loc_mem[loc_raddr];
    end
  end

  // Constant pool
  logic [PW-1:0] pool_raddr, pool_waddr;
  assign pool_raddr = in_if.operand[PW-1:0];
  assign pool_waddr = ir_opnd_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (pw_en) pool_mem[pool_waddr] <= ir_pval_r;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (pw_en && pool_waddr == pool_raddr) pool_q_r <= ir_pval_r;
      else                                   pool_q_r <= pool_mem[pool_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      ir_v_r     <= 1'b0;
      ov_r       <= 1'b0;
      sp_r       <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + LW'(1);
        if (32'(clr_idx_r) == LOCAL_COUNT - 1) clr_busy_r <= 1'b0;
      end
      if (in_fire)      ir_v_r <= 1'b1;
      else if (ex_fire) ir_v_r <= 1'b0;
      if (ex_fire)           ov_r <= 1'b1;
      else if (out_if.ready) ov_r <= 1'b0;
      sp_r <= sp_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < TR; i++) tos_r[i] <= tos_nxt[i];
    if (in_fire) begin
      ir_op_r   <= in_if.opcode;
      ir_opnd_r <= in_if.operand;
      ir_inc_r  <= in_if.increment;
      ir_ch_r   <= in_if.in_char;
      ir_end_r  <= in_if.in_end;
      ir_pc_r   <= in_if.pc_now;
      ir_pval_r <= in_if.pool_value;
    end
    if (ex_fire) begin
      o_status_r <= status;
      o_ov_r     <= ok && ov;
      o_char_r   <= (ok && ov) ? a[7:0] : 8'd0;
      o_pw_r     <= ok && pw;
      o_npc_r    <= (ok && pw) ? npc : 32'd0;
      o_depth_r  <= sp_nxt;
      o_top_r    <= (sp_nxt == '0) ? 32'd0 : tos_nxt[0];
    end
  end

  assign out_if.valid      = ov_r;
  assign out_if.status     = o_status_r;
  assign out_if.out_valid  = o_ov_r;
  assign out_if.out_char   = o_char_r;
  assign out_if.pc_written = o_pw_r;
  assign out_if.next_pc    = o_npc_r;
  assign out_if.top_value  = o_top_r;
  assign out_if.depth_now  = o_depth_r;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_if.ready)
    else $error("instruction accepted during local clear");

  a_fault_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_fire && status != sme_pkg::ST_OK) |=> sp_r == $past(sp_r))
    else $error("faulting instruction changed the stack");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire |=> out_if.valid)
    else $error("executed instruction left no result");
`endif

endmodule
